// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-edge implication
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-edge implication
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/cfc_pkg.sv =====
`default_nettype none

package cfc_pkg;

  localparam int MAX_WAYPOINTS   = 1024;
  localparam int AW              = $clog2(MAX_WAYPOINTS);
  localparam int NW              = AW + 1;
  localparam int COORD_W         = 32;
  localparam int S_W             = 31;
  localparam int HEAD_W          = 16;
  localparam int KIND_W          = 2;
  localparam int CNT_W           = 11;
  localparam int CFG_IDX_W       = 2;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int Z_FRAC          = 30;
  localparam int CORDIC_STEPS    = 16;
  localparam int GUARD_BITS      = 8;
  localparam int VW              = 40;   // values into and out of the CORDIC
  localparam int CW              = 48;   // CORDIC datapath
  localparam int ZW              = 36;   // Q6.30 angles
  localparam int SW              = 56;   // arc-length accumulator
  localparam int GAIN_W          = 30;

  localparam logic [KIND_W-1:0] OP_LOAD      = 2'd0;
  localparam logic [KIND_W-1:0] OP_TO_FRENET = 2'd1;
  localparam logic [KIND_W-1:0] OP_TO_CART   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd2;

  localparam logic signed [ZW-1:0]   Q30_PI         = 36'sd3373259426;
  localparam logic signed [ZW-1:0]   Q30_HALF_PI    = 36'sd1686629713;
  localparam logic signed [ZW+1:0]   Q30_QUARTER_PI = 38'sd843314857;
  localparam logic signed [ZW+1:0]   Q30_TWO_PI     = 38'sd6746518852;
  localparam logic signed [VW-1:0]   NEAR_LIMIT     = 40'sd25600000;
  localparam logic signed [COORD_W-1:0] CENTER_X_RESET = 32'sd256000;
  localparam logic signed [COORD_W-1:0] CENTER_Y_RESET = 32'sd512000;
  localparam logic [GAIN_W-1:0]      INV_GAIN       = 30'd652032874;

  typedef struct packed {
    logic                 start;
    logic                 rot;
    logic signed [VW-1:0] a;
    logic signed [VW-1:0] b;
    logic signed [ZW-1:0] z;
  } cordic_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [VW-1:0] ra;
    logic signed [VW-1:0] rb;
    logic signed [ZW-1:0] ang;
  } cordic_res_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 36'sd843314857;
      5'd1:    v = 36'sd497837829;
      5'd2:    v = 36'sd263043837;
      5'd3:    v = 36'sd133525159;
      5'd4:    v = 36'sd67021687;
      5'd5:    v = 36'sd33543516;
      5'd6:    v = 36'sd16775851;
      5'd7:    v = 36'sd8388437;
      5'd8:    v = 36'sd4194283;
      5'd9:    v = 36'sd2097149;
      5'd10:   v = 36'sd1048576;
      5'd11:   v = 36'sd524288;
      5'd12:   v = 36'sd262144;
      5'd13:   v = 36'sd131072;
      5'd14:   v = 36'sd65536;
      5'd15:   v = 36'sd32768;
      5'd16:   v = 36'sd16384;
      5'd17:   v = 36'sd8192;
      5'd18:   v = 36'sd4096;
      5'd19:   v = 36'sd2048;
      5'd20:   v = 36'sd1024;
      5'd21:   v = 36'sd512;
      5'd22:   v = 36'sd256;
      5'd23:   v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cartesian_frenet_converter.sv =====
// A load or an unused opcode goes straight to the output state once the request is taken;
// both conversions fetch table entries and run the shared CORDIC, whose run takes 16
// iterations plus gain removal; each entry visited in the nearest search and in the
// arc-length sum costs one run plus control and fetch states.
// Throughput: one request at a time, the next taken the cycle after the result is registered.
`default_nettype none

module cartesian_frenet_converter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cfc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cfc_pkg::COORD_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cfc_pkg::KIND_W-1:0]           opcode,
  input  logic [cfc_pkg::AW-1:0]               wp_index,
  input  logic signed [cfc_pkg::COORD_W-1:0]   pos_a,
  input  logic signed [cfc_pkg::COORD_W-1:0]   pos_b,
  input  logic [cfc_pkg::S_W-1:0]              wp_s,
  input  logic signed [cfc_pkg::HEAD_W-1:0]    heading,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cfc_pkg::KIND_W-1:0]           result_kind,
  output logic signed [cfc_pkg::COORD_W-1:0]   out_a,
  output logic signed [cfc_pkg::COORD_W-1:0]   out_b
);
  import cfc_pkg::*;

  `include "assert_macros.svh"

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FETCH  = 5'd1;
  localparam logic [4:0] S_CWAIT  = 5'd2;
  localparam logic [4:0] S_FIN    = 5'd3;
  localparam logic [4:0] F_SCAN_V = 5'd4;
  localparam logic [4:0] F_SCAN_C = 5'd5;
  localparam logic [4:0] F_HEAD   = 5'd6;
  localparam logic [4:0] F_TURN   = 5'd7;
  localparam logic [4:0] F_PREV   = 5'd8;
  localparam logic [4:0] F_SEG    = 5'd9;
  localparam logic [4:0] F_DEG    = 5'd10;
  localparam logic [4:0] F_ROT1   = 5'd11;
  localparam logic [4:0] F_ROT2   = 5'd12;
  localparam logic [4:0] F_ROT3   = 5'd13;
  localparam logic [4:0] F_CP     = 5'd14;
  localparam logic [4:0] F_CR     = 5'd15;
  localparam logic [4:0] F_SUM0   = 5'd16;
  localparam logic [4:0] F_SUM1   = 5'd17;
  localparam logic [4:0] F_SUM2   = 5'd18;
  localparam logic [4:0] F_SUM3   = 5'd19;
  localparam logic [4:0] F_FIN    = 5'd20;
  localparam logic [4:0] C_SCAN   = 5'd21;
  localparam logic [4:0] C_PICK   = 5'd22;
  localparam logic [4:0] C_Q      = 5'd23;
  localparam logic [4:0] C_VEC    = 5'd24;
  localparam logic [4:0] C_ROT    = 5'd25;
  localparam logic [4:0] C_OUT    = 5'd26;

  localparam int TW = ZW + 2;

  // waypoint tables
  logic signed [COORD_W-1:0] mem_x [MAX_WAYPOINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_WAYPOINTS];
  logic [S_W-1:0]            mem_s [MAX_WAYPOINTS];
  logic [AW-1:0]             raddr;
  logic signed [COORD_W-1:0] rx, ry;
  logic [S_W-1:0]            rs;

  logic [4:0]                state, ret;
  logic [CNT_W-1:0]          wp_count;
  logic signed [COORD_W-1:0] cen_x, cen_y;

  logic [KIND_W-1:0]         op_r;
  logic signed [COORD_W-1:0] px, py, xp, yp, xa, ya, pend_a, pend_b;
  logic signed [HEAD_W-1:0]  theta;
  logic [NW-1:0]             k;
  logic [AW-1:0]             best, seg, prev;
  logic signed [VW-1:0]      bestd, xx, xy, along, dabs, prx, pry, cp, cr;
  logic signed [ZW-1:0]      hang;
  logic signed [SW-1:0]      sacc;

  cordic_req_t creq;
  cordic_res_t cres;

  logic                 in_acc, wr_en, hit, turn;
  logic [NW-1:0]        n_used, n_last, kp1, kp2, p_c, q_c;
  logic [AW-1:0]        best_nxt, best_adv, prev_c;
  logic signed [VW-1:0] px_v, py_v, rx_v, ry_v, rs_v, xp_v, yp_v, xa_v, ya_v;
  logic signed [VW-1:0] segx, segy, cxv, cyv, mag, alen;
  logic signed [TW-1:0] diff, adiff, alt, dmin;
  logic signed [SW-1:0] stot;

  function automatic logic signed [VW-1:0] sx32(input logic signed [COORD_W-1:0] v);
    return {{(VW-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [SW-1:0] wide(input logic signed [VW-1:0] v);
    return {{(SW-VW){v[VW-1]}}, v};
  endfunction

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = {{(SW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    lo = {{(SW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};
    if (v > hi) return hi[COORD_W-1:0];
    if (v < lo) return lo[COORD_W-1:0];
    return v[COORD_W-1:0];
  endfunction

  cfc_cordic u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .res (cres)
  );

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (opcode == OP_LOAD) && ({1'b0, wp_index} < NW'(MAX_WAYPOINTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wp_index] <= pos_a;
      mem_y[wp_index] <= pos_b;
      mem_s[wp_index] <= wp_s;
    end
    rx <= mem_x[raddr];
    ry <= mem_y[raddr];
    rs <= mem_s[raddr];
  end

  always_comb begin
    if (wp_count == '0)
      n_used = NW'(1);
    else if (wp_count > CNT_W'(MAX_WAYPOINTS))
      n_used = NW'(MAX_WAYPOINTS);
    else
      n_used = NW'(wp_count);
  end
  assign n_last = n_used - 1'b1;
  assign kp1    = k + 1'b1;
  assign kp2    = k + NW'(2);

  assign px_v = sx32(px);
  assign py_v = sx32(py);
  assign rx_v = sx32(rx);
  assign ry_v = sx32(ry);
  assign rs_v = {{(VW-S_W){1'b0}}, rs};
  assign xp_v = sx32(xp);
  assign yp_v = sx32(yp);
  assign xa_v = sx32(xa);
  assign ya_v = sx32(ya);
  assign mag  = cres.ra;
  assign segx = rx_v - xp_v;
  assign segy = ry_v - yp_v;
  assign cxv  = sx32(cen_x) - xp_v;
  assign cyv  = sx32(cen_y) - yp_v;
  assign alen = along[VW-1] ? -along : along;
  assign stot = sacc + wide(alen);

  assign hit      = mag < bestd;
  assign best_nxt = hit ? k[AW-1:0] : best;

  // heading against bearing to the nearest entry, folded into [0, pi]
  assign diff  = ({{(TW-ZW){theta[HEAD_W-1]}}, ZW'(theta)} <<< (Z_FRAC - ANGLE_FRAC_BITS))
               - {{(TW-ZW){cres.ang[ZW-1]}}, cres.ang};
  assign adiff = diff[TW-1] ? -diff : diff;
  assign alt   = Q30_TWO_PI - adiff;
  assign dmin  = (alt < adiff) ? alt : adiff;
  assign turn  = dmin > Q30_QUARTER_PI;

  always_comb begin
    best_adv = best;
    if (turn)
      best_adv = ({1'b0, best} == n_last) ? '0 : best + 1'b1;
    prev_c = (best_adv == '0) ? n_last[AW-1:0] : best_adv - 1'b1;
  end

  assign p_c = (k == '0) ? '0 : k - 1'b1;
  assign q_c = (p_c + 1'b1 == n_used) ? '0 : p_c + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      creq.start <= 1'b0;
      wp_count   <= CNT_W'(1);
      cen_x      <= CENTER_X_RESET;
      cen_y      <= CENTER_Y_RESET;
    end else begin
      if ((state == S_FIN) && (!out_valid || !out_stall))
        out_valid <= 1'b1;
      else if (out_valid && !out_stall)
        out_valid <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_COUNT:    wp_count <= cfg_data[CNT_W-1:0];
          REG_CENTER_X: cen_x    <= cfg_data;
          REG_CENTER_Y: cen_y    <= cfg_data;
          default:      ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_r   <= opcode;
            px     <= pos_a;
            py     <= pos_b;
            theta  <= heading;
            pend_a <= '0;
            pend_b <= '0;
            k      <= '0;
            raddr  <= '0;
            case (opcode)
              OP_TO_FRENET: begin
                best  <= '0;
                bestd <= NEAR_LIMIT;
                ret   <= F_SCAN_V;
                state <= S_FETCH;
              end
              OP_TO_CART: begin
                ret   <= C_SCAN;
                state <= S_FETCH;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_FETCH: state <= ret;
        S_CWAIT: begin
          creq.start <= 1'b0;
          if (cres.done)
            state <= ret;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            result_kind <= op_r;
            out_a       <= pend_a;
            out_b       <= pend_b;
            state       <= S_IDLE;
          end
        end
        F_SCAN_V: begin
          creq.start <= 1'b1;
          creq.rot   <= 1'b0;
          creq.a     <= px_v - rx_v;
          creq.b     <= py_v - ry_v;
          creq.z     <= '0;
          ret        <= F_SCAN_C;
          state      <= S_CWAIT;
        end
        F_SCAN_C: begin
          if (hit) begin
            bestd <= mag;
            best  <= k[AW-1:0];
          end
          state <= S_FETCH;
          if (k == n_last) begin
            raddr <= best_nxt;
            ret   <= F_HEAD;
          end else begin
            k     <= kp1;
            raddr <= kp1[AW-1:0];
            ret   <= F_SCAN_V;
          end
        end
        F_HEAD: begin
          creq.start <= 1'b1;
          creq.rot   <= 1'b0;
          creq.a     <= rx_v - px_v;
          creq.b     <= ry_v - py_v;
          creq.z     <= '0;
          ret        <= F_TURN;
          state      <= S_CWAIT;
        end
        F_TURN: begin
          seg   <= best_adv;
          prev  <= prev_c;
          raddr <= prev_c;
          ret   <= F_PREV;
          state <= S_FETCH;
        end
        F_PREV: begin
          xp    <= rx;
          yp    <= ry;
          raddr <= seg;
          ret   <= F_SEG;
          state <= S_FETCH;
        end
        F_SEG: begin
          xx         <= px_v - xp_v;
          xy         <= py_v - yp_v;
          creq.start <= 1'b1;
          creq.rot   <= 1'b0;
          creq.z     <= '0;
          state      <= S_CWAIT;
          if ((segx == '0) && (segy == '0)) begin
            // degenerate segment: project onto its start
            along  <= '0;
            prx    <= '0;
            pry    <= '0;
            creq.a <= px_v - xp_v;
            creq.b <= py_v - yp_v;
            ret    <= F_DEG;
          end else begin
            creq.a <= segx;
            creq.b <= segy;
            ret    <= F_ROT1;
          end
        end
        F_DEG: begin
          dabs  <= mag;
          state <= F_CP;
        end
        F_ROT1: begin
          hang       <= cres.ang;
          creq.start <= 1'b1;
          creq.rot   <= 1'b1;
          creq.a     <= xx;
          creq.b     <= xy;
          creq.z     <= -cres.ang;
          ret        <= F_ROT2;
          state      <= S_CWAIT;
        end
        F_ROT2: begin
          along      <= cres.ra;
          dabs       <= cres.rb[VW-1] ? -cres.rb : cres.rb;
          creq.start <= 1'b1;
          creq.rot   <= 1'b1;
          creq.a     <= cres.ra;
          creq.b     <= '0;
          creq.z     <= hang;
          ret        <= F_ROT3;
          state      <= S_CWAIT;
        end
        F_ROT3: begin
          prx   <= cres.ra;
          pry   <= cres.rb;
          state <= F_CP;
        end
        F_CP: begin
          creq.start <= 1'b1;
          creq.rot   <= 1'b0;
          creq.a     <= cxv - xx;
          creq.b     <= cyv - xy;
          creq.z     <= '0;
          ret        <= F_CR;
          state      <= S_CWAIT;
        end
        F_CR: begin
          cp         <= mag;
          creq.start <= 1'b1;
          creq.rot   <= 1'b0;
          creq.a     <= cxv - prx;
          creq.b     <= cyv - pry;
          creq.z     <= '0;
          ret        <= F_SUM0;
          state      <= S_CWAIT;
        end
        F_SUM0: begin
          cr   <= mag;
          sacc <= '0;
          k    <= '0;
          if (prev == '0) begin
            state <= F_FIN;
          end else begin
            raddr <= '0;
            ret   <= F_SUM1;
            state <= S_FETCH;
          end
        end
        F_SUM1: begin
          xa    <= rx;
          ya    <= ry;
          raddr <= kp1[AW-1:0];
          ret   <= F_SUM2;
          state <= S_FETCH;
        end
        F_SUM2: begin
          // xa, ya advance to the far end of this segment
          xa         <= rx;
          ya         <= ry;
          creq.start <= 1'b1;
          creq.rot   <= 1'b0;
          creq.a     <= rx_v - xa_v;
          creq.b     <= ry_v - ya_v;
          creq.z     <= '0;
          ret        <= F_SUM3;
          state      <= S_CWAIT;
        end
        F_SUM3: begin
          sacc <= sacc + wide(mag);
          k    <= kp1;
          if (kp1 == {1'b0, prev}) begin
            state <= F_FIN;
          end else begin
            raddr <= kp2[AW-1:0];
            ret   <= F_SUM2;
            state <= S_FETCH;
          end
        end
        F_FIN: begin
          pend_a <= sat32(stot);
          pend_b <= sat32((cp <= cr) ? wide(-dabs) : wide(dabs));
          state  <= S_FIN;
        end
        C_SCAN: begin
          if (px_v > rs_v) begin
            k <= kp1;
            if (kp1 < n_used) begin
              raddr <= kp1[AW-1:0];
              ret   <= C_SCAN;
              state <= S_FETCH;
            end else begin
              state <= C_PICK;
            end
          end else begin
            state <= C_PICK;
          end
        end
        C_PICK: begin
          seg   <= p_c[AW-1:0];
          raddr <= q_c[AW-1:0];
          ret   <= C_Q;
          state <= S_FETCH;
        end
        C_Q: begin
          xa    <= rx;
          ya    <= ry;
          raddr <= seg;
          ret   <= C_VEC;
          state <= S_FETCH;
        end
        C_VEC: begin
          creq.start <= 1'b1;
          creq.rot   <= 1'b0;
          creq.a     <= xa_v - rx_v;
          creq.b     <= ya_v - ry_v;
          creq.z     <= '0;
          ret        <= C_ROT;
          state      <= S_CWAIT;
        end
        C_ROT: begin
          creq.start <= 1'b1;
          creq.rot   <= 1'b1;
          creq.a     <= px_v - rs_v;
          creq.b     <= -py_v;
          creq.z     <= cres.ang;
          ret        <= C_OUT;
          state      <= S_CWAIT;
        end
        C_OUT: begin
          pend_a <= sat32(wide(rx_v + cres.ra));
          pend_b <= sat32(wide(ry_v + cres.rb));
          state  <= S_FIN;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NXT(a_busy_after_req, clk, rst, in_acc, in_stall)
  `ASSERT_IMP(a_start_in_wait, clk, rst, creq.start, state == S_CWAIT)
  `ASSERT_NXT(a_fetch_returns, clk, rst, state == S_FETCH, state == $past(ret))
  `ASSERT_IMP(a_scan_in_range, clk, rst, state == F_SCAN_C, k <= n_last)

endmodule

`default_nettype wire

// ===== hw/rtl/cfc_cordic.sv =====
`default_nettype none

module cfc_cordic (
  input  logic                 clk,
  input  logic                 rst,
  input  cfc_pkg::cordic_req_t req,
  output cfc_pkg::cordic_res_t res
);
  import cfc_pkg::*;

  localparam int IT_W  = $clog2(CORDIC_STEPS);
  localparam int HW    = CW / 2;
  localparam int PW    = HW + GAIN_W;
  localparam int SUM_W = PW + HW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ITER = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  localparam logic [2:0] PH_XLO = 3'd0;
  localparam logic [2:0] PH_XHI = 3'd1;
  localparam logic [2:0] PH_YLO = 3'd2;
  localparam logic [2:0] PH_YHI = 3'd3;
  localparam logic [2:0] PH_END = 3'd4;

  localparam logic [IT_W-1:0]  IT_LAST = IT_W'(CORDIC_STEPS - 1);
  localparam logic [SUM_W-1:0] RND     = SUM_W'(1) << 21;

  logic [1:0]           st;
  logic                 rot;
  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [IT_W-1:0]      it;
  logic [2:0]           ph;
  logic [PW-1:0]        prod, lo;

  logic signed [CW-1:0] xs, ys, x0, y0, sx, sy;
  logic signed [ZW-1:0] z0, at;
  logic [CW-1:0]        mx, my;
  logic [HW-1:0]        mul_in;
  logic [PW-1:0]        mul_p;
  logic                 cw;

  // drop the gain and guard bits, round half away from zero
  function automatic logic signed [VW-1:0] unscale(input logic [PW-1:0] l,
                                                   input logic [PW-1:0] h,
                                                   input logic neg);
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] r;
    sum = {h, {HW{1'b0}}} + {{HW{1'b0}}, l};
    r = sum >> 16;
    r = r + RND;
    r = r >> 22;
    return neg ? -$signed(r[VW-1:0]) : $signed(r[VW-1:0]);
  endfunction

  assign xs = {{(CW-VW){req.a[VW-1]}}, req.a} <<< GUARD_BITS;
  assign ys = {{(CW-VW){req.b[VW-1]}}, req.b} <<< GUARD_BITS;

  always_comb begin
    x0 = xs;
    y0 = ys;
    z0 = '0;
    if (!req.rot) begin
      if (xs[CW-1]) begin
        x0 = -xs;
        y0 = -ys;
        z0 = ys[CW-1] ? -Q30_PI : Q30_PI;
      end
    end else begin
      z0 = req.z;
      if (req.z > Q30_HALF_PI) begin
        x0 = -xs;
        y0 = -ys;
        z0 = req.z - Q30_PI;
      end else if (req.z < -Q30_HALF_PI) begin
        x0 = -xs;
        y0 = -ys;
        z0 = req.z + Q30_PI;
      end
    end
  end

  assign sx = x >>> it;
  assign sy = y >>> it;
  assign at = atan_q30(5'(it));
  assign cw = rot ? z[ZW-1] : (!y[CW-1] && (y != '0));

  assign mx = x[CW-1] ? $unsigned(-x) : $unsigned(x);
  assign my = y[CW-1] ? $unsigned(-y) : $unsigned(y);

  always_comb begin
    case (ph)
      PH_XLO:  mul_in = mx[HW-1:0];
      PH_XHI:  mul_in = mx[CW-1:HW];
      PH_YLO:  mul_in = my[HW-1:0];
      PH_YHI:  mul_in = my[CW-1:HW];
      default: mul_in = '0;
    endcase
  end

  assign mul_p = {{GAIN_W{1'b0}}, mul_in} * {{HW{1'b0}}, INV_GAIN};

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (req.start) begin
            rot <= req.rot;
            it  <= '0;
            if (!req.rot && (req.a == '0) && (req.b == '0)) begin
              res.ra   <= '0;
              res.rb   <= '0;
              res.ang  <= '0;
              res.done <= 1'b1;
            end else begin
              x  <= x0;
              y  <= y0;
              z  <= z0;
              st <= ST_ITER;
            end
          end
        end
        ST_ITER: begin
          if (cw) begin
            x <= x + sy;
            y <= y - sx;
            z <= z + at;
          end else begin
            x <= x - sy;
            y <= y + sx;
            z <= z - at;
          end
          it <= it + 1'b1;
          if (it == IT_LAST) begin
            ph <= PH_XLO;
            st <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (ph)
            PH_XLO: begin
              prod <= mul_p;
              ph   <= PH_XHI;
            end
            PH_XHI: begin
              lo   <= prod;
              prod <= mul_p;
              ph   <= PH_YLO;
            end
            PH_YLO: begin
              res.ra <= unscale(lo, prod, x[CW-1]);
              prod   <= mul_p;
              ph     <= PH_YHI;
            end
            PH_YHI: begin
              lo   <= prod;
              prod <= mul_p;
              ph   <= PH_END;
            end
            PH_END: begin
              res.rb   <= unscale(lo, prod, y[CW-1]);
              res.ang  <= z;
              res.done <= 1'b1;
              st       <= ST_IDLE;
            end
            default: st <= ST_IDLE;
          endcase
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
